// ===== design/mvks_pkg.sv =====
// Package with the sizes, codes and state type of the multi-version key store.
package mvks_pkg;

	// Table geometry.
	localparam int MAX_KEYS     = 256;
	localparam int MAX_VERSIONS = 16;
	localparam int KEY_W        = $clog2(MAX_KEYS);
	localparam int VER_W        = $clog2(MAX_VERSIONS);
	localparam int CNT_W        = $clog2(MAX_VERSIONS + 1);
	localparam int SLOT_W       = KEY_W + VER_W;
	localparam int SLOTS        = MAX_KEYS * MAX_VERSIONS;

	// Field widths of the ports.
	localparam int OP_W     = 2;
	localparam int KEY_IN_W = 16;
	localparam int VAL_W    = 64;
	localparam int STAMP_W  = 64;
	localparam int STATUS_W = 2;

	// Key limit, one bit wider than the key field so it can hold the table size.
	localparam logic [KEY_IN_W:0] KEY_LIMIT = (KEY_IN_W + 1)'(MAX_KEYS);

	// Operation codes.
	localparam logic [OP_W-1:0] OP_SET   = 2'd0;
	localparam logic [OP_W-1:0] OP_GET   = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

	// Status codes.
	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_GET
	} state_t;

endpackage

// ===== design/multi_version_key_store_unit.sv =====
// Top level of the multi-version key store: sequencer, count memory and version memory.
//
// Usage: drive operation, key and value and raise start; the beat is taken at a
// rising edge where start is high and busy is low. Results come out on status,
// has_row, row_value, row_stamp and last, each for exactly one cycle while done
// is high; the receiver cannot stall, so every result must be taken as it comes.
// Sequencing:
//   A set or get on a valid key reads the per-key count memory first, in a
//   lookup state. A set answers from the lookup state, and so does a get on an
//   empty key. A get of n versions then reads the version memory and gives
//   one version per cycle, oldest first, last on the final one, with busy
//   high until the last version has been read from the version memory.
//   A clear, an out-of-range key or an unused code answers straight from the
//   idle state, and the block can take a new beat in the very next cycle.
// Reset: arst_n clears the sequencer, the stamp counter and the per-key valid
// bits, so every key reads as empty; the version memory needs no clearing.
// A clear drops every valid bit and keeps the stamp counter.
module multi_version_key_store_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [mvks_pkg::OP_W-1:0]          operation,
	input  logic [mvks_pkg::KEY_IN_W-1:0]      key,
	input  logic signed [mvks_pkg::VAL_W-1:0]  value,
	output logic                               busy,
	output logic                               done,
	output logic [mvks_pkg::STATUS_W-1:0]      status,
	output logic                               has_row,
	output logic signed [mvks_pkg::VAL_W-1:0]  row_value,
	output logic [mvks_pkg::STAMP_W-1:0]       row_stamp,
	output logic                               last
);
	import mvks_pkg::*;

	state_t state_q, state_d;

	// Registers of the item at work.
	logic [OP_W-1:0]     op_q;
	logic [KEY_W-1:0]    key_q;
	logic [VAL_W-1:0]    value_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [CNT_W-1:0]    idx_q;
	logic [STAMP_W-1:0]  stamp_q;
	logic [MAX_KEYS-1:0] valid_q;

	// Memories and their read data.
	logic [CNT_W-1:0]         cnt_mem [MAX_KEYS];
	logic [CNT_W-1:0]         cnt_rdata;
	logic [VAL_W+STAMP_W-1:0] dat_mem [SLOTS];
	logic [VAL_W+STAMP_W-1:0] dat_rdata;

	// Result registers.
	logic                 done_q;
	logic [STATUS_W-1:0]  status_q;
	logic                 has_row_q;
	logic [VAL_W-1:0]     row_value_q;
	logic [STAMP_W-1:0]   row_stamp_q;
	logic                 last_q;

	// Combinational control.
	logic                 accept;
	logic                 key_ok;
	logic                 op_lookup;
	logic [CNT_W-1:0]     cur_cnt;
	logic [VER_W-1:0]     rd_idx;
	logic [SLOT_W-1:0]    dat_raddr;
	logic [SLOT_W-1:0]    dat_waddr;
	logic [STAMP_W-1:0]   stamp_next;
	logic                 res_load;
	logic [STATUS_W-1:0]  res_status;
	logic                 res_has_row;
	logic [VAL_W-1:0]     res_value;
	logic [STAMP_W-1:0]   res_stamp;
	logic                 res_last;
	logic                 wr_en;
	logic                 clear_all;
	logic                 idx_start;
	logic                 idx_inc;

	// Decode of the incoming beat.
	assign accept     = start && (state_q == ST_IDLE);
	assign key_ok     = {1'b0, key} < KEY_LIMIT;
	assign op_lookup  = operation inside {OP_SET, OP_GET};

	// A key whose valid bit is clear holds no versions.
	assign cur_cnt    = valid_q[key_q] ? cnt_rdata : '0;
	assign stamp_next = stamp_q + STAMP_W'(1);

	// Version memory addresses: slot zero in lookup, then the running index.
	assign rd_idx    = (state_q == ST_LOOKUP) ? '0 : idx_q[VER_W-1:0];
	assign dat_raddr = {key_q, rd_idx};
	assign dat_waddr = {key_q, cur_cnt[VER_W-1:0]};

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && key_ok && op_lookup) begin
					state_d = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				if ((op_q == OP_GET) && (cur_cnt != '0)) begin
					state_d = ST_GET;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_GET: begin
				if (idx_q == cnt_q) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer: result beat, memory writes and index control.
	always_comb begin
		res_load    = 1'b0;
		res_status  = STATUS_OK;
		res_has_row = 1'b0;
		res_value   = '0;
		res_stamp   = '0;
		res_last    = 1'b1;
		wr_en       = 1'b0;
		clear_all   = 1'b0;
		idx_start   = 1'b0;
		idx_inc     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept && !(key_ok && op_lookup)) begin
					res_load = 1'b1;
					if (op_lookup) begin
						res_status = STATUS_RANGE;
					end
					clear_all = (operation == OP_CLEAR);
				end
			end
			ST_LOOKUP: begin
				if (op_q == OP_SET) begin
					res_load = 1'b1;
					if (cur_cnt >= CNT_W'(MAX_VERSIONS)) begin
						res_status = STATUS_FULL;
					end else begin
						wr_en       = 1'b1;
						res_has_row = 1'b1;
						res_value   = value_q;
						res_stamp   = stamp_next;
					end
				end else if (cur_cnt == '0) begin
					res_load = 1'b1;
				end else begin
					idx_start = 1'b1;
				end
			end
			ST_GET: begin
				res_load    = 1'b1;
				res_has_row = 1'b1;
				res_value   = dat_rdata[VAL_W+STAMP_W-1:STAMP_W];
				res_stamp   = dat_rdata[STAMP_W-1:0];
				res_last    = (idx_q == cnt_q);
				idx_inc     = (idx_q != cnt_q);
			end
			default: begin
				res_load = 1'b0;
			end
		endcase
	end

	// Count memory: read every cycle at the incoming key, written on a stored set.
	always_ff @(posedge clk) begin
		cnt_rdata <= cnt_mem[key[KEY_W-1:0]];
		if (wr_en) begin
			cnt_mem[key_q] <= cur_cnt + CNT_W'(1);
		end
	end

	// Version memory: value and stamp side by side in one word.
	always_ff @(posedge clk) begin
		dat_rdata <= dat_mem[dat_raddr];
		if (wr_en) begin
			dat_mem[dat_waddr] <= {value_q, stamp_next};
		end
	end

	// Control state: sequencer, valid bits, stamp counter and result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= '0;
			stamp_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= res_load;
			if (clear_all) begin
				valid_q <= '0;
			end else if (wr_en) begin
				valid_q[key_q] <= 1'b1;
			end
			if (wr_en) begin
				stamp_q <= stamp_next;
			end
		end
	end

	// Item registers and the get index.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= operation;
			key_q   <= key[KEY_W-1:0];
			value_q <= value;
		end
		if (idx_start) begin
			cnt_q <= cur_cnt;
			idx_q <= CNT_W'(1);
		end else if (idx_inc) begin
			idx_q <= idx_q + CNT_W'(1);
		end
	end

	// Result payload registers.
	always_ff @(posedge clk) begin
		if (res_load) begin
			status_q    <= res_status;
			has_row_q   <= res_has_row;
			row_value_q <= res_value;
			row_stamp_q <= res_stamp;
			last_q      <= res_last;
		end
	end

	assign busy      = (state_q != ST_IDLE);
	assign done      = done_q;
	assign status    = status_q;
	assign has_row   = has_row_q;
	assign row_value = $signed(row_value_q);
	assign row_stamp = row_stamp_q;
	assign last      = last_q;

endmodule

// ===== dv/multi_version_key_store_unit_checker.sv =====
// Checker that predicts and compares every result beat of the multi-version key store.
`timescale 1ns / 1ps
module multi_version_key_store_unit_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic                                busy,
	input  logic [mvks_pkg::OP_W-1:0]           operation,
	input  logic [mvks_pkg::KEY_IN_W-1:0]       key,
	input  logic signed [mvks_pkg::VAL_W-1:0]   value,
	input  logic                                done,
	input  logic [mvks_pkg::STATUS_W-1:0]       status,
	input  logic                                has_row,
	input  logic signed [mvks_pkg::VAL_W-1:0]   row_value,
	input  logic [mvks_pkg::STAMP_W-1:0]        row_stamp,
	input  logic                                last,
	output int                                  mismatches,
	output int                                  awaited,
	output int                                  rows_read,
	output int                                  full_rejects,
	output int                                  range_rejects
);
	import mvks_pkg::*;

	// One result beat as the block should present it.
	typedef struct {
		logic [STATUS_W-1:0]    status;
		logic                   has_row;
		logic signed [VAL_W-1:0] row_value;
		logic [STAMP_W-1:0]     row_stamp;
		logic                   last;
	} version_result_t;

	version_result_t         expected_results[$];
	version_result_t         oldest;
	int unsigned             held_versions [MAX_KEYS];
	logic signed [VAL_W-1:0] held_value [MAX_KEYS][MAX_VERSIONS];
	logic [STAMP_W-1:0]      held_stamp [MAX_KEYS][MAX_VERSIONS];
	logic [STAMP_W-1:0]      stamp_issued;

	// Appends one expected result beat at the tail of the queue.
	task automatic queue_result(input logic [STATUS_W-1:0] st,
			input logic row, input logic signed [VAL_W-1:0] v, input logic [STAMP_W-1:0] s,
			input logic fin);
		version_result_t r;
		r.status    = st;
		r.has_row   = row;
		r.row_value = v;
		r.row_stamp = s;
		r.last      = fin;
		expected_results.insert(expected_results.size(), r);
	endtask

	// Applies one accepted beat to the mirrored tables and queues the results it causes.
	task automatic predict_beat(input logic [OP_W-1:0] op, input logic [KEY_IN_W-1:0] k,
			input logic signed [VAL_W-1:0] v);
		int unsigned      n;
		bit               in_range;
		logic [KEY_W-1:0] row_key;
		in_range = int'(k) < MAX_KEYS;
		row_key  = k[KEY_W-1:0];
		case (op)
			OP_SET: begin
				if (!in_range) begin
					range_rejects++;
					queue_result(STATUS_RANGE, 1'b0, '0, '0, 1'b1);
				end else if (held_versions[row_key] >= MAX_VERSIONS) begin
					full_rejects++;
					queue_result(STATUS_FULL, 1'b0, '0, '0, 1'b1);
				end else begin
					// The stamp counter wraps on its own at 64 bits.
					stamp_issued = stamp_issued + STAMP_W'(1);
					n = held_versions[row_key];
					held_value[row_key][VER_W'(n)] = v;
					held_stamp[row_key][VER_W'(n)] = stamp_issued;
					held_versions[row_key] = n + 1;
					queue_result(STATUS_OK, 1'b1, v, stamp_issued, 1'b1);
				end
			end
			OP_GET: begin
				if (!in_range) begin
					range_rejects++;
					queue_result(STATUS_RANGE, 1'b0, '0, '0, 1'b1);
				end else if (held_versions[row_key] == 0) begin
					queue_result(STATUS_OK, 1'b0, '0, '0, 1'b1);
				end else begin
					n = held_versions[row_key];
					for (int i = 0; i < n; i++) begin
						rows_read++;
						queue_result(STATUS_OK, 1'b1, held_value[row_key][VER_W'(i)],
							held_stamp[row_key][VER_W'(i)], i == n - 1);
					end
				end
			end
			OP_CLEAR: begin
				// Versions are dropped, the stamp counter carries on.
				foreach (held_versions[i]) held_versions[i] = 0;
				queue_result(STATUS_OK, 1'b0, '0, '0, 1'b1);
			end
			default: begin
				queue_result(STATUS_OK, 1'b0, '0, '0, 1'b1);
			end
		endcase
	endtask

	// Results are compared before the beat of the same edge is predicted, since a
	// result can never belong to a beat taken at that very edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (held_versions[i]) held_versions[i] = 0;
			stamp_issued = '0;
			expected_results.delete();
			awaited       = 0;
			mismatches    = 0;
			rows_read     = 0;
			full_rejects  = 0;
			range_rejects = 0;
		end else begin
			if (done) begin
				if (expected_results.size() == 0) begin
					$error("result beat with no expectation waiting");
					mismatches++;
				end else begin
					oldest = expected_results.pop_front();
					if (oldest.status !== status) begin
						$error("status: expected %0d, actual %0d", oldest.status, status);
						mismatches++;
					end
					if (oldest.has_row !== has_row) begin
						$error("has_row: expected %0d, actual %0d", oldest.has_row, has_row);
						mismatches++;
					end
					if (oldest.row_value !== row_value) begin
						$error("row_value: expected %0d, actual %0d", oldest.row_value, row_value);
						mismatches++;
					end
					if (oldest.row_stamp !== row_stamp) begin
						$error("row_stamp: expected %0d, actual %0d", oldest.row_stamp, row_stamp);
						mismatches++;
					end
					if (oldest.last !== last) begin
						$error("last: expected %0d, actual %0d", oldest.last, last);
						mismatches++;
					end
				end
			end
			if (start && !busy) begin
				predict_beat(operation, key, value);
			end
			awaited = expected_results.size();
		end
	end

endmodule

// ===== dv/multi_version_key_store_unit_tb.sv =====
// Testbench top for the multi-version key store: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module multi_version_key_store_unit_tb;
	import mvks_pkg::*;

	localparam logic [OP_W-1:0] OP_SPARE    = 2'd3;
	localparam int              BEAT_TARGET = 210;
	localparam int              STALL_LIMIT = 600;

	logic                    clk;
	logic                    arst_n;
	logic                    start;
	logic [OP_W-1:0]         operation;
	logic [KEY_IN_W-1:0]     key;
	logic signed [VAL_W-1:0] value;
	logic                    busy;
	logic                    done;
	logic [STATUS_W-1:0]     status;
	logic                    has_row;
	logic signed [VAL_W-1:0] row_value;
	logic [STAMP_W-1:0]      row_stamp;
	logic                    last;

	int mismatches;
	int awaited;
	int rows_read;
	int full_rejects;
	int range_rejects;
	int beats_sent   = 0;
	int stall_cycles = 0;
	bit steady       = 1'b0;

	logic [KEY_IN_W-1:0] hot_keys [4] = '{16'd0, 16'd1, 16'd2, KEY_IN_W'(MAX_KEYS - 1)};

	multi_version_key_store_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.operation (operation),
		.key       (key),
		.value     (value),
		.busy      (busy),
		.done      (done),
		.status    (status),
		.has_row   (has_row),
		.row_value (row_value),
		.row_stamp (row_stamp),
		.last      (last)
	);

	multi_version_key_store_unit_checker result_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.operation     (operation),
		.key           (key),
		.value         (value),
		.done          (done),
		.status        (status),
		.has_row       (has_row),
		.row_value     (row_value),
		.row_stamp     (row_stamp),
		.last          (last),
		.mismatches    (mismatches),
		.awaited       (awaited),
		.rows_read     (rows_read),
		.full_rejects  (full_rejects),
		.range_rejects (range_rejects)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Watchdog: ends the run when neither a beat nor a result moves for too long.
	always @(posedge clk) begin
		if ((start && !busy) || done) stall_cycles <= 0;
		else stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("multi_version_key_store_unit regression: fail");
			$finish;
		end
	end

	function automatic logic signed [VAL_W-1:0] random_word();
		return {$urandom(), $urandom()};
	endfunction

	// Mostly a few busy keys, so lists fill up; some other keys and some out of range.
	function automatic logic [KEY_IN_W-1:0] pick_key();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 70) return hot_keys[2'($urandom_range(0, 3))];
		if (roll < 85) return KEY_IN_W'($urandom_range(0, MAX_KEYS - 1));
		return KEY_IN_W'($urandom_range(MAX_KEYS, 65535));
	endfunction

	// Presents one beat, after a random pause unless pacing is steady, and holds it until the block takes it.
	task automatic issue_beat(input logic [OP_W-1:0] op, input logic [KEY_IN_W-1:0] k,
			input logic signed [VAL_W-1:0] v);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start     <= 1'b1;
		operation <= op;
		key       <= k;
		value     <= v;
		do @(posedge clk); while (busy);
		beats_sent++;
	endtask

	initial begin
		int                      roll;
		int                      burst;
		logic [KEY_IN_W-1:0]     focus;
		logic signed [VAL_W-1:0] fill_value;

		arst_n    <= 1'b0;
		start     <= 1'b0;
		operation <= OP_SET;
		key       <= '0;
		value     <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Fill the highest key to the limit, starting with extreme values, then overflow it and read it back.
		for (int i = 0; i <= MAX_VERSIONS; i++) begin
			case (i)
				0: fill_value = {1'b1, {(VAL_W - 1){1'b0}}};
				1: fill_value = {1'b0, {(VAL_W - 1){1'b1}}};
				2: fill_value = '0;
				3: fill_value = '1;
				default: fill_value = random_word();
			endcase
			issue_beat(OP_SET, KEY_IN_W'(MAX_KEYS - 1), fill_value);
		end
		issue_beat(OP_GET, KEY_IN_W'(MAX_KEYS - 1), random_word());

		// Out-of-range keys, an empty key, the spare code and a clear, then a get and a set after it.
		issue_beat(OP_SET, KEY_IN_W'(MAX_KEYS), random_word());
		issue_beat(OP_SET, '1, random_word());
		issue_beat(OP_GET, '1, random_word());
		issue_beat(OP_GET, '0, random_word());
		issue_beat(OP_SPARE, KEY_IN_W'($urandom()), random_word());
		issue_beat(OP_CLEAR, '1, random_word());
		issue_beat(OP_GET, KEY_IN_W'(MAX_KEYS - 1), random_word());
		issue_beat(OP_SET, '0, random_word());

		// Random traffic: bursts of sets on one key read back at the end, mixed with
		// single beats of every kind; pacing switches between back-to-back and gaps.
		while (beats_sent < BEAT_TARGET) begin
			if ($urandom_range(0, 29) == 0) steady = !steady;
			roll = $urandom_range(0, 99);
			if (roll < 12) begin
				focus = hot_keys[2'($urandom_range(0, 3))];
				burst = $urandom_range(8, 20);
				repeat (burst) issue_beat(OP_SET, focus, random_word());
				issue_beat(OP_GET, focus, random_word());
			end else if (roll < 55) begin
				issue_beat(OP_SET, pick_key(), random_word());
			end else if (roll < 90) begin
				issue_beat(OP_GET, pick_key(), random_word());
			end else if (roll < 95) begin
				issue_beat(OP_CLEAR, KEY_IN_W'($urandom()), random_word());
			end else begin
				issue_beat(OP_SPARE, KEY_IN_W'($urandom()), random_word());
			end
		end
		start <= 1'b0;

		// Drain the expected results, then let any stray result show up before the verdict.
		@(negedge clk);
		while (awaited != 0) @(negedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);

		$display("Run covered %0d beats of sets, gets, clears and the spare code.", beats_sent);
		$display("%0d stored versions read back, %0d full-key and %0d out-of-range rejections.",
			rows_read, full_rejects, range_rejects);
		if (mismatches == 0) begin
			$display("multi_version_key_store_unit regression: pass");
		end else begin
			$display("multi_version_key_store_unit regression: fail");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
design/mvks_pkg.sv
design/multi_version_key_store_unit.sv
dv/multi_version_key_store_unit_checker.sv
dv/multi_version_key_store_unit_tb.sv
